// File: rtl/core/uerm_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo range meter - shared package
// Item types, operation and status codes, timer width and the constants
// for the width-to-distance scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package uerm_pkg;

  // Timer width of the capture unit feeding the echo stamps
  localparam int TIMER_BITS = 16;

  localparam int OP_W     = 2;
  localparam int STAMP_W  = 16;
  localparam int STATUS_W = 2;
  localparam int DIST_W   = 15;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PERIOD  = 2'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL    = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  // Poll status codes
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

  // distance = width * 3422 / 10000 = width * 1711 / 5000, taken as
  // floor(width * DIST_MULT / 2^DIST_SHIFT). The reciprocal is rounded up;
  // with 2^DIST_SHIFT > 5000 * 2^TIMER_BITS the rounding error never
  // crosses an integer step.
  localparam int SCALE_NUM  = 1711;
  localparam int SCALE_DEN  = 5000;
  localparam int DIST_SHIFT = TIMER_BITS + 13;
  localparam int MULT_BITS  = DIST_SHIFT - 1;
  localparam longint unsigned DIST_MULT_L =
    (((64'd1 << DIST_SHIFT) * SCALE_NUM) + (SCALE_DEN - 1)) / SCALE_DEN;
  localparam logic [MULT_BITS-1:0] DIST_MULT = MULT_BITS'(DIST_MULT_L);
  localparam int PROD_W = TIMER_BITS + MULT_BITS;
  localparam int QUO_W  = PROD_W - DIST_SHIFT;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [STAMP_W-1:0] capture_time;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance_mm;
  } out_t;

  // Request from the input stage to the state unit
  typedef struct packed {
    logic fire;
    in_t  item;
  } state_req_t;

  function automatic logic op_has_result(input logic [OP_W-1:0] op);
    return (op == OP_POLL) || (op == OP_READ);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/uerm_dist.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo range meter - distance scaler
// Scales a pulse width in microseconds to millimetres with one constant
// multiply and a shift, saturating at the field maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module uerm_dist (
  input  wire uerm_pkg::timer_t               width,
  output logic [uerm_pkg::DIST_W-1:0]         distance_mm
);

  localparam int CMP_W = (uerm_pkg::QUO_W > uerm_pkg::DIST_W) ?
                         uerm_pkg::QUO_W : uerm_pkg::DIST_W;

  logic [uerm_pkg::PROD_W-1:0] prod;
  logic [uerm_pkg::QUO_W-1:0]  quo;
  logic [CMP_W-1:0]            quo_ext;

  always_comb begin
    prod    = uerm_pkg::PROD_W'(width) * uerm_pkg::PROD_W'(uerm_pkg::DIST_MULT);
    quo     = prod[uerm_pkg::PROD_W-1:uerm_pkg::DIST_SHIFT];
    quo_ext = CMP_W'(quo);
    if (quo_ext > CMP_W'(uerm_pkg::DIST_MAX)) begin
      distance_mm = uerm_pkg::DIST_MAX;
    end else begin
      distance_mm = quo_ext[uerm_pkg::DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/uerm_state.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo range meter - measurement state
// Holds the edge stamps, pulse width and status flags, updates them for
// each item leaving the input register and forms the poll/read result.
// ----------------------------------------------------------------------------
`default_nettype none

module uerm_state (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire uerm_pkg::state_req_t req,
  output uerm_pkg::out_t            result
);

  uerm_pkg::timer_t rising_stamp_r, rising_stamp_nxt;
  uerm_pkg::timer_t pulse_width_r, pulse_width_nxt;
  logic             awaiting_falling_r, awaiting_falling_nxt;
  logic             done_flag_r, done_flag_nxt;
  logic             error_flag_r, error_flag_nxt;

  uerm_pkg::timer_t            stamp;
  logic [uerm_pkg::DIST_W-1:0] distance_mm;

  uerm_dist u_dist (
    .width       (pulse_width_r),
    .distance_mm (distance_mm)
  );

  always_comb begin
    stamp                = uerm_pkg::TIMER_BITS'(req.item.capture_time);
    rising_stamp_nxt     = rising_stamp_r;
    pulse_width_nxt      = pulse_width_r;
    awaiting_falling_nxt = awaiting_falling_r;
    done_flag_nxt        = done_flag_r;
    error_flag_nxt       = error_flag_r;
    result               = '0;

    case (req.item.operation)
      uerm_pkg::OP_PERIOD: begin
        // force the next capture to be a rising edge
        awaiting_falling_nxt = 1'b0;
        if (!done_flag_r) begin
          error_flag_nxt = 1'b1;
        end
      end
      uerm_pkg::OP_CAPTURE: begin
        if (!awaiting_falling_r) begin
          rising_stamp_nxt     = stamp;
          awaiting_falling_nxt = 1'b1;
        end else begin
          pulse_width_nxt      = stamp - rising_stamp_r;
          done_flag_nxt        = 1'b1;
          awaiting_falling_nxt = 1'b0;
        end
      end
      uerm_pkg::OP_POLL: begin
        // done wins; only the reported flag is dropped
        if (done_flag_r) begin
          result.status = uerm_pkg::ST_NEW;
          done_flag_nxt = 1'b0;
        end else if (error_flag_r) begin
          result.status  = uerm_pkg::ST_FAIL;
          error_flag_nxt = 1'b0;
        end else begin
          result.status = uerm_pkg::ST_NONE;
        end
      end
      uerm_pkg::OP_READ: begin
        result.distance_mm = distance_mm;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rising_stamp_r     <= '0;
      pulse_width_r      <= '0;
      awaiting_falling_r <= 1'b0;
      done_flag_r        <= 1'b0;
      error_flag_r       <= 1'b0;
    end else if (req.fire) begin
      rising_stamp_r     <= rising_stamp_nxt;
      pulse_width_r      <= pulse_width_nxt;
      awaiting_falling_r <= awaiting_falling_nxt;
      done_flag_r        <= done_flag_nxt;
      error_flag_r       <= error_flag_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ultrasonic_echo_range_meter.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo range meter - top level
// Times echo pulses from capture stamps and reports status and distance.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying one event (period end, echo edge
//           capture, poll, distance read) per transfer.
//   out_* : valid/ready channel; polls and distance reads each give one
//           result, period ends and captures give none.
//   An accepted item waits in the input register, is processed there and,
//   if it has a result, loads the output register as it leaves the input
//   register; out_valid is driven from the output register.
//   Throughput is one item per cycle unless a stalled result blocks it; the longest path is the constant
//   multiply of the distance scaler between the width register and the
//   output register.
//   A stalled receiver holds the output register; the item behind it waits
//   in the input register and in_ready drops only while both are full and
//   the waiting item needs the output. Items with no result pass on.
//   Synchronous reset clears stamps, width, flags and both valid bits; the
//   block expects a rising edge first.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_range_meter (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire uerm_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output uerm_pkg::out_t       out_data
);

  logic                 s1_valid_r;
  uerm_pkg::in_t        s1_item_r;
  logic                 out_valid_r;
  uerm_pkg::out_t       out_data_r;

  logic                 needs_out;
  logic                 out_free;
  logic                 s1_fire;
  uerm_pkg::state_req_t req;
  uerm_pkg::out_t       result;

  always_comb begin
    needs_out = uerm_pkg::op_has_result(s1_item_r.operation);
    out_free  = !out_valid_r || out_ready;
    s1_fire   = s1_valid_r && (!needs_out || out_free);
    in_ready  = !s1_valid_r || s1_fire;
    req.fire  = s1_fire;
    req.item  = s1_item_r;
  end

  uerm_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && needs_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && needs_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/uerm_checker.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo range meter - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uerm_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire uerm_pkg::out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == uerm_pkg::ST_NONE ||
                   out_data.status == uerm_pkg::ST_NEW ||
                   out_data.status == uerm_pkg::ST_FAIL))
    else $error("bad status code");

  // a poll carries no distance, a read carries no status
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == uerm_pkg::ST_NONE ||
                   out_data.distance_mm == '0))
    else $error("status and distance both set");

endmodule

bind ultrasonic_echo_range_meter uerm_checker u_uerm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/echo_range_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo range meter result checker
// Watches both channels of the range meter and keeps its own copy of the
// echo timing state. Every accepted input transfer updates that copy, and
// every poll or distance read queues its expected result. Results leaving
// the block are compared in order against that queue.
// ----------------------------------------------------------------------------
module echo_range_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  uerm_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  uerm_pkg::out_t out_data,
  output int             mismatches,
  output int             outstanding,
  output int             checked
);

  // speed of sound 342.2 m/s with the width in microseconds
  localparam longint unsigned SOUND_NUM    = 3422;
  localparam longint unsigned SOUND_DEN    = 10000;
  localparam int              REPORT_LIMIT = 10;

  uerm_pkg::timer_t rise_stamp;
  logic             want_falling;
  uerm_pkg::timer_t echo_width;
  logic             done_pend;
  logic             error_pend;
  uerm_pkg::out_t   reply_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
  end

  // Advance the echo timing state by one event; returns 1 when it gives a result
  function automatic logic apply_event(input uerm_pkg::in_t ev,
                                       output uerm_pkg::out_t reply);
    uerm_pkg::timer_t stamp;
    longint unsigned  mm;
    stamp = uerm_pkg::timer_t'(ev.capture_time);
    reply = '0;
    case (ev.operation)
      uerm_pkg::OP_PERIOD: begin
        want_falling = 1'b0;
        if (!done_pend) error_pend = 1'b1;
        return 1'b0;
      end
      uerm_pkg::OP_CAPTURE: begin
        if (!want_falling) begin
          rise_stamp   = stamp;
          want_falling = 1'b1;
        end else begin
          echo_width   = stamp - rise_stamp;
          done_pend    = 1'b1;
          want_falling = 1'b0;
        end
        return 1'b0;
      end
      uerm_pkg::OP_POLL: begin
        // done wins over error; only the reported flag is cleared
        if (done_pend) begin
          reply.status = uerm_pkg::ST_NEW;
          done_pend    = 1'b0;
        end else if (error_pend) begin
          reply.status = uerm_pkg::ST_FAIL;
          error_pend   = 1'b0;
        end else begin
          reply.status = uerm_pkg::ST_NONE;
        end
        return 1'b1;
      end
      default: begin
        mm = longint'(echo_width) * SOUND_NUM / SOUND_DEN;
        if (mm > uerm_pkg::DIST_MAX) mm = uerm_pkg::DIST_MAX;
        reply.distance_mm = uerm_pkg::DIST_W'(mm);
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    uerm_pkg::out_t want;
    uerm_pkg::out_t reply;
    logic           has_reply;
    if (!rst_n) begin
      rise_stamp   = '0;
      want_falling = 1'b0;
      echo_width   = '0;
      done_pend    = 1'b0;
      error_pend   = 1'b0;
      reply_q.delete();
    end else begin
      // the result leaving now always belongs to an older transfer
      if (out_valid && out_ready) begin
        checked++;
        if (reply_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected result: status %0d distance %0d", $time,
                     out_data.status, out_data.distance_mm);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (out_data.status !== want.status ||
              out_data.distance_mm !== want.distance_mm) begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: result mismatch: status exp %0d got %0d, %s %0d got %0d",
                       $time, want.status, out_data.status, "distance exp",
                       want.distance_mm, out_data.distance_mm);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        has_reply = apply_event(in_data, reply);
        if (has_reply) reply_q.push_back(reply);
      end
    end
    outstanding <= reply_q.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo range meter testbench
// Drives period ends, echo captures, polls and distance reads into the range
// meter with bursty input and a stalling receiver, and leaves prediction
// and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb;

  localparam int ITEM_TARGET   = 800;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_EVERY   = 200;

  typedef enum int {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic           clk   = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  uerm_pkg::in_t  in_data  = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  uerm_pkg::out_t out_data;

  logic hold_req = 1'b0;
  logic steady   = 1'b0;
  int   burst_left;
  int   sent_cnt = 0;
  int   mismatches;
  int   outstanding;
  int   checked;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ultrasonic_echo_range_meter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  echo_range_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Offer one event and hold it until the transfer; idle between bursts
  task automatic offer(input logic [uerm_pkg::OP_W-1:0]    op,
                       input logic [uerm_pkg::STAMP_W-1:0] stamp);
    in_valid <= 1'b1;
    in_data  <= '{operation: op, capture_time: stamp};
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Pause until every expected result is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One echo measurement with random content, sometimes broken by a period end
  task automatic measure_cycle();
    logic [uerm_pkg::STAMP_W-1:0] rise;
    logic [uerm_pkg::STAMP_W-1:0] width;
    case ($urandom_range(0, 3))
      0:       width = uerm_pkg::STAMP_W'($urandom_range(0, 16'hFFFF));
      1:       width = uerm_pkg::STAMP_W'($urandom_range(0, 63));
      2:       width = 16'hFFFF - uerm_pkg::STAMP_W'($urandom_range(0, 63));
      default: width = uerm_pkg::STAMP_W'($urandom_range(100, 30000));
    endcase
    rise = uerm_pkg::STAMP_W'($urandom_range(0, 16'hFFFF));
    if ($urandom_range(0, 3) == 0) offer(uerm_pkg::OP_PERIOD, uerm_pkg::STAMP_W'($urandom));
    offer(uerm_pkg::OP_CAPTURE, rise);
    // lost echo: period ends between the edges
    if ($urandom_range(0, 9) == 0) offer(uerm_pkg::OP_PERIOD, uerm_pkg::STAMP_W'($urandom));
    offer(uerm_pkg::OP_CAPTURE, rise + width);
    if ($urandom_range(0, 4) == 0) offer(uerm_pkg::OP_PERIOD, uerm_pkg::STAMP_W'($urandom));
    if ($urandom_range(0, 3) != 0) offer(uerm_pkg::OP_POLL, uerm_pkg::STAMP_W'($urandom));
    if ($urandom_range(0, 4) != 0) offer(uerm_pkg::OP_READ, uerm_pkg::STAMP_W'($urandom));
    if ($urandom_range(0, 2) == 0) offer(uerm_pkg::OP_POLL, uerm_pkg::STAMP_W'($urandom));
  endtask

  // Stall the receiver for a long stretch while results keep coming
  task automatic squeeze_output();
    hold_req <= 1'b1;
    steady = 1'b1;
    repeat (40) offer($urandom_range(0, 1) ? uerm_pkg::OP_POLL : uerm_pkg::OP_READ,
                      uerm_pkg::STAMP_W'($urandom));
    steady = 1'b0;
  endtask

  initial begin : receiver
    rx_mode_e mode;
    int       left;
    mode = RX_STREAM;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          RX_STREAM: out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
          RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
          default:   out_ready <= (left % 4 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic squeezed;
    int   next_drain;
    squeezed   = 1'b0;
    next_drain = DRAIN_EVERY;
    burst_left = $urandom_range(1, 24);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // fresh state, then an error flag raised and reported
    offer(uerm_pkg::OP_POLL, 16'hFFFF);
    offer(uerm_pkg::OP_READ, 16'h0000);
    offer(uerm_pkg::OP_PERIOD, 16'hFFFF);
    offer(uerm_pkg::OP_POLL, 16'h0000);
    offer(uerm_pkg::OP_POLL, 16'h0000);
    // widest pulse, then a period end with done pending leaves error alone
    offer(uerm_pkg::OP_CAPTURE, 16'h0000);
    offer(uerm_pkg::OP_CAPTURE, 16'hFFFF);
    offer(uerm_pkg::OP_READ, 16'h0000);
    offer(uerm_pkg::OP_PERIOD, 16'h0000);
    offer(uerm_pkg::OP_POLL, 16'h0000);
    offer(uerm_pkg::OP_POLL, 16'h0000);
    // rising edge lost to a period end, then a wrapping pulse: both flags set
    offer(uerm_pkg::OP_CAPTURE, 16'h1234);
    offer(uerm_pkg::OP_PERIOD, 16'h0000);
    offer(uerm_pkg::OP_CAPTURE, 16'hFFF0);
    offer(uerm_pkg::OP_CAPTURE, 16'h0010);
    offer(uerm_pkg::OP_POLL, 16'h0000);
    offer(uerm_pkg::OP_POLL, 16'h0000);
    offer(uerm_pkg::OP_POLL, 16'h0000);
    offer(uerm_pkg::OP_READ, 16'hFFFF);
    // zero and one tick widths
    offer(uerm_pkg::OP_CAPTURE, 16'h5555);
    offer(uerm_pkg::OP_CAPTURE, 16'h5555);
    offer(uerm_pkg::OP_READ, 16'h0000);
    offer(uerm_pkg::OP_CAPTURE, 16'hAAAA);
    offer(uerm_pkg::OP_CAPTURE, 16'hAAAB);
    offer(uerm_pkg::OP_READ, 16'h0000);
    drain_results();

    while (sent_cnt < ITEM_TARGET) begin
      steady = (sent_cnt >= 550 && sent_cnt < 650);
      if (!squeezed && sent_cnt >= 300) begin
        squeeze_output();
        squeezed = 1'b1;
      end
      if (sent_cnt >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      if ($urandom_range(0, 9) < 7) measure_cycle();
      else repeat ($urandom_range(1, 6))
        offer(uerm_pkg::OP_W'($urandom_range(0, 3)), uerm_pkg::STAMP_W'($urandom));
    end
    drain_results();

    $display("tb: %0d events sent, %0d results compared", sent_cnt, checked);
    $display("tb: wrapped and extreme widths, lost echoes, flag priority, long output stall");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
